### hw/rtl/sfcd_pkg.sv
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // register indexes on the write port
  localparam logic [1:0] REG_CRC_POLY  = 2'd0;
  localparam logic [1:0] REG_CRC_INIT  = 2'd1;
  localparam logic [1:0] REG_WORDS     = 2'd2;

  // byte positions inside a frame
  localparam logic [2:0] POS_W0_HI  = 3'd0;
  localparam logic [2:0] POS_W0_LO  = 3'd1;
  localparam logic [2:0] POS_W0_CRC = 3'd2;
  localparam logic [2:0] POS_W1_HI  = 3'd3;
  localparam logic [2:0] POS_W1_LO  = 3'd4;
  localparam logic [2:0] POS_W1_CRC = 3'd5;

  // conversion constants, hundredths
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  typedef struct packed {
    logic [7:0] crc_poly;
    logic [7:0] crc_init;
    logic       one_word;
  } cfg_t;

  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [1:0]  status;
  } frame_rec_t;

  // msb-first crc-8 over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ poly;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### hw/rtl/sfcd_front.sv
`timescale 1ns / 1ps

module sfcd_front (
  input  logic                clk,
  input  logic                rst,
  input  sfcd_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic                push_ready,
  output logic                push_valid,
  output sfcd_pkg::frame_rec_t push_rec
);
  import sfcd_pkg::*;

  logic [2:0]  pos, pos_next, eff_pos;
  logic [7:0]  crc, crc_next;
  logic [15:0] word_a, word_a_next;
  logic [15:0] word_b, word_b_next;
  logic [1:0]  flags, flags_next;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;
  assign eff_pos  = frame_start ? POS_W0_HI : pos;

  always_comb begin
    pos_next    = eff_pos + 3'd1;
    crc_next    = crc;
    word_a_next = word_a;
    word_b_next = word_b;
    flags_next  = flags;
    push_valid  = 1'b0;
    push_rec    = '0;
    unique case (eff_pos)
      POS_W0_HI: begin
        crc_next    = crc8_byte(cfg.crc_init, rx_byte, cfg.crc_poly);
        word_a_next = {rx_byte, 8'h00};
        word_b_next = '0;
        flags_next  = '0;
      end
      POS_W0_LO: begin
        crc_next    = crc8_byte(crc, rx_byte, cfg.crc_poly);
        word_a_next = {word_a[15:8], rx_byte};
      end
      POS_W0_CRC: begin
        flags_next[0] = flags[0] | (crc != rx_byte);
        if (cfg.one_word) begin
          push_valid = take;
          push_rec   = '{first_word: word_a, second_word: 16'h0000,
                         status: {1'b0, flags_next[0]}};
          pos_next   = POS_W0_HI;
        end
      end
      POS_W1_HI: begin
        crc_next    = crc8_byte(cfg.crc_init, rx_byte, cfg.crc_poly);
        word_b_next = {rx_byte, 8'h00};
      end
      POS_W1_LO: begin
        crc_next    = crc8_byte(crc, rx_byte, cfg.crc_poly);
        word_b_next = {word_b[15:8], rx_byte};
      end
      POS_W1_CRC: begin
        flags_next[1] = flags[1] | (crc != rx_byte);
        push_valid = take;
        push_rec   = '{first_word: word_a, second_word: word_b, status: flags_next};
        pos_next   = POS_W0_HI;
      end
      default: begin
        pos_next = POS_W0_HI;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_W0_HI;
    end else if (take) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      crc    <= crc_next;
      word_a <= word_a_next;
      word_b <= word_b_next;
      flags  <= flags_next;
    end
  end

endmodule

### hw/rtl/sfcd_queue.sv
`timescale 1ns / 1ps

module sfcd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  sfcd_pkg::frame_rec_t push_rec,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output sfcd_pkg::frame_rec_t pop_rec
);
  import sfcd_pkg::*;

  frame_rec_t           mem [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr, rd_ptr;
  logic [QueueAw:0]     count;
  logic                 do_push, do_pop;

  assign push_ready = (count != (QueueAw+1)'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_rec    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QueueAw'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QueueAw'(1);
      if (do_push && !do_pop)      count <= count + (QueueAw+1)'(1);
      else if (do_pop && !do_push) count <= count - (QueueAw+1)'(1);
    end
  end

endmodule

### hw/rtl/sfcd_back.sv
`timescale 1ns / 1ps

module sfcd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  sfcd_pkg::frame_rec_t pop_rec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          first_word,
  output logic [15:0]          second_word,
  output logic signed [14:0]   temp_centi_deg,
  output logic [13:0]          humid_centi_pct,
  output logic [1:0]           frame_status
);
  import sfcd_pkg::*;

  logic        s1_valid, s1_load, s2_load;
  frame_rec_t  s1_rec;
  logic [30:0] s1_prod_t;
  logic [29:0] s1_prod_h;

  assign s2_load   = !out_valid || out_ready;
  assign s1_load   = !s1_valid || s2_load;
  assign pop_ready = s1_load;

  // stage one: constant multiplies
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && pop_valid) begin
      s1_rec    <= pop_rec;
      s1_prod_t <= 31'(TEMP_SCALE) * 31'(pop_rec.first_word);
      s1_prod_h <= 30'(HUMID_SCALE) * 30'(pop_rec.second_word);
    end
  end

  // stage two: scale down, offset, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      first_word      <= s1_rec.first_word;
      second_word     <= s1_rec.second_word;
      temp_centi_deg  <= $signed(s1_prod_t[30:16] - TEMP_OFFSET);
      humid_centi_pct <= s1_prod_h[29:16];
      frame_status    <= s1_rec.status;
    end
  end

endmodule

### hw/rtl/sensor_frame_crc_decoder_unit.sv
`timescale 1ns / 1ps

// sensor frame decoder with crc-8 check
// input stream: one received byte per request on s_axis, tuser marks the first
// byte of a new frame. each 16-bit word arrives high byte, low byte, crc byte;
// a frame is one word or two words (temperature then humidity).
// output stream: one request per completed frame on m_axis carrying both raw
// words, converted temperature and humidity in hundredths, and crc status.
// throughput: one byte per cycle while the frame queue is not full; the crc
// update is eight unrolled steps. a finished frame passes through the queue,
// the stage-one register (constant multiplies) and the output register.
// a 4-deep frame queue sits between the byte decoder and the conversion
// pipeline; the input stalls only when that queue is full, which takes a
// receiver stall of several frames. bytes are still taken while a result
// waits on m_axis.
// reset: crc polynomial 0x31, initial value 0xff, two words per frame,
// queue and pipeline empty, frame position at the first byte.
// cfg writes take effect at once; write only while no frame is in flight.

module sensor_frame_crc_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] first_word, [31:16] second_word, [46:32] temp_centi_deg,
  // [60:47] humid_centi_pct, [62:61] frame_status, [63] zero
  output logic [63:0] m_axis_tdata
);
  import sfcd_pkg::*;

  logic [7:0] crc_poly, crc_init;
  logic [1:0] words_cfg;
  cfg_t       cfg;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  frame_rec_t  push_rec, pop_rec;

  logic [15:0]        first_word, second_word;
  logic signed [14:0] temp_centi_deg;
  logic [13:0]        humid_centi_pct;
  logic [1:0]         frame_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly  <= 8'h31;
      crc_init  <= 8'hff;
      words_cfg <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_POLY: crc_poly  <= cfg_data;
        REG_CRC_INIT: crc_init  <= cfg_data;
        REG_WORDS:    words_cfg <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // 0 and 3 behave as two words
  assign cfg = '{crc_poly: crc_poly, crc_init: crc_init, one_word: (words_cfg == 2'd1)};

  sfcd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser),
    .push_ready  (push_ready),
    .push_valid  (push_valid),
    .push_rec    (push_rec)
  );

  sfcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  sfcd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_rec         (pop_rec),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .first_word      (first_word),
    .second_word     (second_word),
    .temp_centi_deg  (temp_centi_deg),
    .humid_centi_pct (humid_centi_pct),
    .frame_status    (frame_status)
  );

  assign m_axis_tdata = {1'b0, frame_status, humid_centi_pct, temp_centi_deg,
                         second_word, first_word};

endmodule
